/* design/nps3d_pkg.sv */
// ----------------------------------------------------------------------------
// nps3d_pkg
// Shared sizes, codes and types for the 3D nearest point search block.
// ----------------------------------------------------------------------------
package nps3d_pkg;

  // Store depth and coordinate precision
  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 20;

  // Fixed port field widths
  localparam int FUNC_W  = 2;
  localparam int FIELD_W = 20;
  localparam int PIDX_W  = 10;
  localparam int DIST_W  = 42;
  localparam int STAT_W  = 2;

  // Derived internal widths
  localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int CMP_W  = (CNT_W > PIDX_W) ? CNT_W : PIDX_W;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int SAT_W  = (SUM_W > DIST_W) ? SUM_W : DIST_W;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Item function codes
  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD  = 2'd0,
    FN_QUERY = 2'd1,
    FN_CLEAR = 2'd2
  } func_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_BADQ  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } point_t;

endpackage

/* design/nearest_point_search_3d.sv */
// ----------------------------------------------------------------------------
// nearest_point_search_3d
// Brute-force nearest neighbor search (squared Euclidean) over a 3D point store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one beat per item: func_i
//   selects load, query or clear. Output channel (out_valid_o / out_stall_i)
//   returns exactly one beat per input beat, in order.
//   Load, clear and rejected items: the result register is loaded at the
//   accepting edge, so the result beat is offered from the next cycle.
//   Query: the block reads the queried point, latches it, then reads one
//   stored point per cycle (single memory read port feeds a 3-stage distance
//   pipe and the running minimum) and lets the pipe drain. The result
//   register is loaded at the end of the drain, and the block takes no new
//   beat meanwhile.
//   A new beat is taken only once the output register is empty or being
//   emptied in that same cycle, so a stalled result simply holds and blocks
//   the input side until it is taken.
//   Reset clears the point count and the output valid; the store contents
//   are not cleared (entries are only read below the count).
//   Ties in distance go to the lowest index, since the scan runs upward and
//   only a strictly smaller distance replaces the current best.
// ----------------------------------------------------------------------------
module nearest_point_search_3d (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [nps3d_pkg::FUNC_W-1:0]          func_i,
  input  logic signed [nps3d_pkg::FIELD_W-1:0]  coord_x_i,
  input  logic signed [nps3d_pkg::FIELD_W-1:0]  coord_y_i,
  input  logic signed [nps3d_pkg::FIELD_W-1:0]  coord_z_i,
  input  logic [nps3d_pkg::PIDX_W-1:0]          point_index_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [nps3d_pkg::PIDX_W-1:0]          nearest_index_o,
  output logic [nps3d_pkg::DIST_W-1:0]          distance_sq_o,
  output logic [nps3d_pkg::STAT_W-1:0]          status_o
);

  localparam int IDX_W  = nps3d_pkg::IDX_W;
  localparam int CNT_W  = nps3d_pkg::CNT_W;
  localparam int CMP_W  = nps3d_pkg::CMP_W;
  localparam int CB     = nps3d_pkg::COORD_BITS;
  localparam int DIFF_W = nps3d_pkg::DIFF_W;
  localparam int SQ_W   = nps3d_pkg::SQ_W;
  localparam int SAT_W  = nps3d_pkg::SAT_W;
  localparam int DIST_W = nps3d_pkg::DIST_W;
  localparam int PIDX_W = nps3d_pkg::PIDX_W;
  localparam int STAT_W = nps3d_pkg::STAT_W;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_FETCHQ = 5'b00010,  // read the queried point
    S_LATCHQ = 5'b00100,  // capture it as the reference
    S_SCAN   = 5'b01000,  // one store read per cycle
    S_DRAIN  = 5'b10000   // let the distance pipe empty
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] scan_q, scan_d;
  logic [IDX_W-1:0] q_q, q_d;
  logic [1:0]       drain_q, drain_d;

  // Point store: one write, one registered read per cycle
  nps3d_pkg::point_t point_mem [nps3d_pkg::MAX_POINTS];
  nps3d_pkg::point_t rdata_q;
  nps3d_pkg::point_t qpt_q;
  nps3d_pkg::point_t wr_pt;
  logic              wr_en;
  logic [IDX_W-1:0]  raddr;

  // Distance pipe
  logic              v1_q, v2_q, v3_q;
  logic [IDX_W-1:0]  idx1_q, idx2_q, idx3_q;
  logic [DIFF_W-1:0] ax_q, ay_q, az_q;
  logic [SQ_W-1:0]   sqx_q, sqy_q, sqz_q;

  // Running minimum
  logic              found_q, found_d;
  logic [DIST_W-1:0] best_dist_q, best_dist_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [PIDX_W-1:0] out_idx_q, out_idx_d;
  logic [DIST_W-1:0] out_dist_q, out_dist_d;
  logic [STAT_W-1:0] out_stat_q, out_stat_d;

  logic accept, out_take, scan_last;

  assign out_take   = out_valid_q && !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign scan_last  = (scan_q == IDX_W'(count_q - CNT_W'(1)));

  assign out_valid_o     = out_valid_q;
  assign nearest_index_o = out_idx_q;
  assign distance_sq_o   = out_dist_q;
  assign status_o        = out_stat_q;

  // Low COORD_BITS of each field, two's complement
  assign wr_pt.x = CB'($unsigned(coord_x_i));
  assign wr_pt.y = CB'($unsigned(coord_y_i));
  assign wr_pt.z = CB'($unsigned(coord_z_i));

  assign raddr = (state_q == S_FETCHQ) ? q_q : scan_q;

  // ---------------------------------------------------------------------------
  // Distance datapath
  // ---------------------------------------------------------------------------
  function automatic logic [DIFF_W-1:0] abs_diff(logic signed [CB-1:0] a,
                                                 logic signed [CB-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  logic [SAT_W-1:0]  sum;
  logic [DIST_W-1:0] dist_sat;

  assign sum      = SAT_W'(sqx_q) + SAT_W'(sqy_q) + SAT_W'(sqz_q);
  assign dist_sat = (sum > SAT_W'(nps3d_pkg::DIST_MAX)) ? nps3d_pkg::DIST_MAX
                                                         : DIST_W'(sum);

  always_comb begin
    found_d     = found_q;
    best_dist_d = best_dist_q;
    best_idx_d  = best_idx_q;
    if (accept) begin
      found_d = 1'b0;
    end else if (v3_q && (!found_q || dist_sat < best_dist_q)) begin
      found_d     = 1'b1;
      best_dist_d = dist_sat;
      best_idx_d  = idx3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    q_d         = q_q;
    drain_d     = drain_q;
    wr_en       = 1'b0;
    out_valid_d = out_take ? 1'b0 : out_valid_q;
    out_idx_d   = out_idx_q;
    out_dist_d  = out_dist_q;
    out_stat_d  = out_stat_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          out_idx_d   = '0;
          out_dist_d  = '0;
          out_stat_d  = nps3d_pkg::STS_OK;
          case (func_i)
            nps3d_pkg::FN_LOAD: begin
              if (count_q == CNT_W'(nps3d_pkg::MAX_POINTS)) begin
                out_stat_d = nps3d_pkg::STS_FULL;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            nps3d_pkg::FN_QUERY: begin
              if (count_q < CNT_W'(2) ||
                  CMP_W'(point_index_i) >= CMP_W'(count_q)) begin
                out_stat_d = nps3d_pkg::STS_BADQ;
              end else begin
                // Result comes later from the scan
                out_valid_d = out_take ? 1'b0 : out_valid_q;
                q_d         = IDX_W'(point_index_i);
                state_d     = S_FETCHQ;
              end
            end
            nps3d_pkg::FN_CLEAR: begin
              count_d = '0;
            end
            default: begin
              out_stat_d = nps3d_pkg::STS_BADQ;
            end
          endcase
        end
      end
      S_FETCHQ: begin
        state_d = S_LATCHQ;
      end
      S_LATCHQ: begin
        scan_d  = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        scan_d = scan_q + IDX_W'(1);
        if (scan_last) begin
          drain_d = 2'd3;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drain_q == 2'd0) begin
          // best_*_d already holds the last point's update
          out_valid_d = 1'b1;
          out_idx_d   = PIDX_W'(best_idx_d);
          out_dist_d  = best_dist_d;
          out_stat_d  = nps3d_pkg::STS_OK;
          state_d     = S_IDLE;
        end else begin
          drain_d = drain_q - 2'd1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      drain_q     <= '0;
      found_q     <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      drain_q     <= drain_d;
      found_q     <= found_d;
      v1_q        <= (state_q == S_SCAN) && (scan_q != q_q);
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q      <= scan_d;
    q_q         <= q_d;
    best_dist_q <= best_dist_d;
    best_idx_q  <= best_idx_d;
    out_idx_q   <= out_idx_d;
    out_dist_q  <= out_dist_d;
    out_stat_q  <= out_stat_d;
    if (state_q == S_LATCHQ) begin
      qpt_q <= rdata_q;
    end
    // stage 1 -> 2: coordinate differences
    idx1_q <= scan_q;
    ax_q   <= abs_diff(rdata_q.x, qpt_q.x);
    ay_q   <= abs_diff(rdata_q.y, qpt_q.y);
    az_q   <= abs_diff(rdata_q.z, qpt_q.z);
    idx2_q <= idx1_q;
    // stage 2 -> 3: squares
    sqx_q  <= SQ_W'(ax_q) * SQ_W'(ax_q);
    sqy_q  <= SQ_W'(ay_q) * SQ_W'(ay_q);
    sqz_q  <= SQ_W'(az_q) * SQ_W'(az_q);
    idx3_q <= idx2_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      point_mem[count_q[IDX_W-1:0]] <= wr_pt;
    end
    rdata_q <= point_mem[raddr];
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(nps3d_pkg::MAX_POINTS))
    else $error("point count beyond store depth");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_IDLE || $past(state_q) == S_DRAIN))
    else $error("result raised outside accept or scan end");

  a_not_self: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_q && state_q != S_IDLE) |-> (best_idx_q != q_q))
    else $error("query point chosen as its own neighbor");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CNT_W'(scan_q) < count_q && CNT_W'(q_q) < count_q))
    else $error("scan or query index outside loaded points");

endmodule
